// ===== rtl/su2aa_pkg.sv =====
// Shared widths, constants, angle table and side-band type for the SU(2) rotation-vector block.
package su2aa_pkg;

  localparam int IN_W          = 18;
  localparam int OUT_W         = 19;
  localparam int IN_FIELDS     = 8;
  localparam int IN_TDATA_W    = 144;
  localparam int OUT_TDATA_W   = 64;
  localparam int SUM_W         = 19;          // doubled axis / cosine sums
  localparam int MAG_W         = 19;          // magnitude of a sum
  localparam int SQ_W          = 37;          // one square
  localparam int SUMSQ_W       = 38;          // sum of three squares
  localparam int GUARD         = 12;
  localparam int SG_W          = 31;          // scaled root
  localparam int SQRT_STEPS    = 31;
  localparam int REM_W         = 33;          // root remainder
  localparam int ANG_BITS      = 30;
  localparam int CORDIC_STEPS  = 31;
  localparam int CW            = 35;          // cordic x/y
  localparam int ZW            = 34;          // cordic angle accumulator
  localparam int THETA_W       = 32;
  localparam int Q_W           = 20;          // quotient bits
  localparam int NUM_W         = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
  localparam logic [Q_W-1:0] POS_LIM    = Q_W'(262143);
  localparam logic [Q_W-1:0] NEG_LIM    = Q_W'(262144);
  localparam logic [OUT_W-1:0] OUT_MAX  = 19'h3FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN  = 19'h40000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1
  };

  typedef struct packed {
    logic signed [SUM_W-1:0]  kc;
    logic [2:0]               neg;
    logic [2:0][MAG_W-1:0]    mag;
    logic                     zero;
  } side_t;

endpackage

// ===== rtl/su2aa_angle.sv =====
// Pipelined integer square root followed by a pipelined CORDIC atan2.
module su2aa_angle import su2aa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vin,
  input  logic [SUMSQ_W-1:0]   sumsq,
  input  side_t                side_in,
  output logic                 vout,
  output logic [THETA_W-1:0]   theta,
  output logic [SG_W-1:0]      sg,
  output side_t                side_out
);

  // square root: one result bit per stage
  logic               sv_r    [SQRT_STEPS];
  logic [REM_W-1:0]   srem_r  [SQRT_STEPS];
  logic [SG_W-1:0]    sroot_r [SQRT_STEPS];
  logic [SUMSQ_W-1:0] srad_r  [SQRT_STEPS];
  side_t              sside_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int I = SQRT_STEPS - 1 - k;
    logic               v_in;
    logic [REM_W-1:0]   rem_in;
    logic [SG_W-1:0]    root_in;
    logic [SUMSQ_W-1:0] rad_in;
    side_t              side_i;
    logic [1:0]         pair;
    logic [REM_W+1:0]   acc;
    logic [REM_W+1:0]   trial;
    logic               take;

    if (k == 0) begin : g_first
      assign v_in    = vin;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sumsq;
      assign side_i  = side_in;
    end else begin : g_next
      assign v_in    = sv_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
      assign rad_in  = srad_r[k-1];
      assign side_i  = sside_r[k-1];
    end

    // radicand is sumsq shifted up by 2*GUARD; low pairs are zero
    if (2*I >= 2*GUARD) begin : g_pair
      assign pair = rad_in[2*I-2*GUARD +: 2];
    end else begin : g_zpair
      assign pair = 2'b00;
    end

    assign acc   = {rem_in, pair};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign take  = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en) begin
        sv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k]  <= take ? REM_W'(acc - trial) : REM_W'(acc);
        sroot_r[k] <= {root_in[SG_W-2:0], take};
        srad_r[k]  <= rad_in;
        sside_r[k] <= side_i;
      end
    end
  end

  // prerotation into the right half plane, then CORDIC vectoring
  logic                  cv_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0]  cx_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0]  cy_r   [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  cz_r   [CORDIC_STEPS+1];
  logic [SG_W-1:0]       csg_r  [CORDIC_STEPS+1];
  side_t                 cside_r[CORDIC_STEPS+1];

  logic signed [CW-1:0] kg;
  logic signed [CW-1:0] sg_ext;

  assign kg     = CW'($signed({sside_r[SQRT_STEPS-1].kc, {GUARD{1'b0}}}));
  assign sg_ext = CW'({1'b0, sroot_r[SQRT_STEPS-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= sv_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (kg < 0) begin
        cx_r[0] <= sg_ext;
        cy_r[0] <= -kg;
        cz_r[0] <= HALF_PI_Q30;
      end else begin
        cx_r[0] <= kg;
        cy_r[0] <= sg_ext;
        cz_r[0] <= '0;
      end
      csg_r[0]   <= sroot_r[SQRT_STEPS-1];
      cside_r[0] <= sside_r[SQRT_STEPS-1];
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] at;

    assign xs = cx_r[k] >>> k;
    assign ys = cy_r[k] >>> k;
    assign at = ZW'(ATAN_TAB[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else if (en) begin
        cv_r[k+1] <= cv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cy_r[k] > 0) begin
          cx_r[k+1] <= cx_r[k] + ys;
          cy_r[k+1] <= cy_r[k] - xs;
          cz_r[k+1] <= cz_r[k] + at;
        end else begin
          cx_r[k+1] <= cx_r[k] - ys;
          cy_r[k+1] <= cy_r[k] + xs;
          cz_r[k+1] <= cz_r[k] - at;
        end
        csg_r[k+1]   <= csg_r[k];
        cside_r[k+1] <= cside_r[k];
      end
    end
  end

  // clamp angle at zero
  logic               tv_r;
  logic [THETA_W-1:0] theta_r;
  logic [SG_W-1:0]    tsg_r;
  side_t              tside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (en) begin
      tv_r <= cv_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= cz_r[CORDIC_STEPS][ZW-1] ? '0 : cz_r[CORDIC_STEPS][THETA_W-1:0];
      tsg_r   <= csg_r[CORDIC_STEPS];
      tside_r <= cside_r[CORDIC_STEPS];
    end
  end

  assign vout     = tv_r;
  assign theta    = theta_r;
  assign sg       = tsg_r;
  assign side_out = tside_r;

endmodule

// ===== rtl/su2aa_div.sv =====
// Three-lane scaling: theta * |axis| / root by pipelined restoring division, then sign and saturation.
module su2aa_div import su2aa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vin,
  input  logic [THETA_W-1:0]            theta,
  input  logic [SG_W-1:0]               sg,
  input  side_t                         side_in,
  output logic                          vout,
  output logic [2:0][OUT_W-1:0]         vec
);

  localparam int SHIFT = ANG_BITS - FRAC_BITS;
  localparam int DEN_W = SG_W + SHIFT;
  localparam int PROD_W = THETA_W + MAG_W;
  localparam int CMP_W = (DEN_W + Q_W > NUM_W) ? DEN_W + Q_W : NUM_W;

  // multiply
  logic               mv_r;
  logic [PROD_W-1:0]  prod_r [3];
  logic [DEN_W-1:0]   mden_r;
  logic [2:0]         mneg_r;
  logic               mzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        prod_r[l] <= PROD_W'(theta) * PROD_W'(side_in.mag[l]);
      end
      mden_r  <= DEN_W'(sg) << SHIFT;
      mneg_r  <= side_in.neg;
      mzero_r <= side_in.zero;
    end
  end

  // rounding offset and overflow check, then one quotient bit per stage
  logic               dv_r   [Q_W+1];
  logic [CMP_W-1:0]   rem_r  [Q_W+1][3];
  logic [Q_W-1:0]     q_r    [Q_W+1][3];
  logic [2:0]         ovf_r  [Q_W+1];
  logic [DEN_W-1:0]   den_r  [Q_W+1];
  logic [2:0]         neg_r  [Q_W+1];
  logic               zero_r [Q_W+1];

  logic [CMP_W-1:0] num [3];
  logic [CMP_W-1:0] den_top;

  assign den_top = CMP_W'(mden_r) << Q_W;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = CMP_W'({prod_r[l], {GUARD{1'b0}}}) + CMP_W'(mden_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= num[l];
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= (num[l] >= den_top);
      end
      den_r[0]  <= mden_r;
      neg_r[0]  <= mneg_r;
      zero_r[0] <= mzero_r;
    end
  end

  for (genvar t = 0; t < Q_W; t++) begin : g_div
    localparam int J = Q_W - 1 - t;
    logic [CMP_W-1:0] dsh;

    assign dsh = CMP_W'(den_r[t]) << J;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[t+1] <= 1'b0;
      end else if (en) begin
        dv_r[t+1] <= dv_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_r[t][l] >= dsh) begin
            rem_r[t+1][l] <= rem_r[t][l] - dsh;
            q_r[t+1][l]   <= q_r[t][l] | (Q_W'(1) << J);
          end else begin
            rem_r[t+1][l] <= rem_r[t][l];
            q_r[t+1][l]   <= q_r[t][l];
          end
        end
        ovf_r[t+1]  <= ovf_r[t];
        den_r[t+1]  <= den_r[t];
        neg_r[t+1]  <= neg_r[t];
        zero_r[t+1] <= zero_r[t];
      end
    end
  end

  // sign and saturate into the output register
  logic                  ov_r;
  logic [2:0][OUT_W-1:0] vec_r;
  logic [2:0][OUT_W-1:0] vec_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (zero_r[Q_W]) begin
        vec_nxt[l] = '0;
      end else if (neg_r[Q_W][l]) begin
        if (ovf_r[Q_W][l] || q_r[Q_W][l] > NEG_LIM) begin
          vec_nxt[l] = OUT_MIN;
        end else begin
          vec_nxt[l] = OUT_W'(-$signed({1'b0, q_r[Q_W][l]}));
        end
      end else begin
        if (ovf_r[Q_W][l] || q_r[Q_W][l] > POS_LIM) begin
          vec_nxt[l] = OUT_MAX;
        end else begin
          vec_nxt[l] = OUT_W'(q_r[Q_W][l]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vout = ov_r;
  assign vec  = vec_r;

endmodule

// ===== rtl/su2_axis_angle_vector.sv =====
// Top level: SU(2) matrix to rotation vector theta * n, fully pipelined.
// Pipeline from an accepted input word to its output word:
//   3 front stages, 31 root stages, 32 CORDIC stages, clamp, 23 divide/output stages.
// Throughput: one word per cycle unless the output register is full and not drained;
//   root, CORDIC and divide stages each do one bit or one step, so no stage iterates.
// Reset: rst_n synchronous, active low; clears all stage valid bits, payload is not reset.
module su2_axis_angle_vector import su2aa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im (18b each)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vec_x, vec_y, vec_z (19b each), zero pad to 64b
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Whole pipe advances when the output register is free or being drained.
  // The first stage can also fill while stalled if it is empty.
  logic en;
  logic ld_a;
  logic va_r;

  assign en        = !out_tvalid || out_tready;
  assign ld_a      = en || !va_r;
  assign in_tready = ld_a;

  // unpack one input word
  logic signed [IN_W-1:0] fld [IN_FIELDS];
  always_comb begin
    for (int i = 0; i < IN_FIELDS; i++) begin
      fld[i] = in_tdata[i*IN_W +: IN_W];
    end
  end

  // stage A: doubled axis and cosine sums, exact
  logic signed [SUM_W-1:0] ax_r, by_r, cz_r, kc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (ld_a) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      ax_r <= SUM_W'(fld[3]) + SUM_W'(fld[5]);   // Im u01 + Im u10
      by_r <= SUM_W'(fld[2]) - SUM_W'(fld[4]);   // Re u01 - Re u10
      cz_r <= SUM_W'(fld[7]) - SUM_W'(fld[1]);   // Im u11 - Im u00
      kc_r <= SUM_W'(fld[0]) + SUM_W'(fld[6]);   // Re u00 + Re u11
    end
  end

  // stage B: squares and magnitudes
  logic                    vb_r;
  logic [SQ_W-1:0]         sq_r [3];
  side_t                   bside_r;
  logic signed [2*SUM_W-1:0] ax_sq, by_sq, cz_sq;
  side_t                   bside_nxt;

  assign ax_sq = ax_r * ax_r;
  assign by_sq = by_r * by_r;
  assign cz_sq = cz_r * cz_r;

  always_comb begin
    bside_nxt.kc     = kc_r;
    bside_nxt.neg    = {cz_r[SUM_W-1], by_r[SUM_W-1], ax_r[SUM_W-1]};
    bside_nxt.mag[0] = ax_r[SUM_W-1] ? MAG_W'(-ax_r) : MAG_W'(ax_r);
    bside_nxt.mag[1] = by_r[SUM_W-1] ? MAG_W'(-by_r) : MAG_W'(by_r);
    bside_nxt.mag[2] = cz_r[SUM_W-1] ? MAG_W'(-cz_r) : MAG_W'(cz_r);
    bside_nxt.zero   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= SQ_W'(ax_sq);
      sq_r[1] <= SQ_W'(by_sq);
      sq_r[2] <= SQ_W'(cz_sq);
      bside_r <= bside_nxt;
    end
  end

  // stage C: sum of squares, zero-axis flag
  logic               vc_r;
  logic [SUMSQ_W-1:0] sumsq_r;
  side_t              cside_r;
  logic [SUMSQ_W-1:0] sumsq_nxt;
  side_t              cside_nxt;

  assign sumsq_nxt = SUMSQ_W'(sq_r[0]) + SUMSQ_W'(sq_r[1]) + SUMSQ_W'(sq_r[2]);

  always_comb begin
    cside_nxt      = bside_r;
    cside_nxt.zero = (sumsq_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq_r <= sumsq_nxt;
      cside_r <= cside_nxt;
    end
  end

  // root and angle
  logic               ang_v;
  logic [THETA_W-1:0] ang_theta;
  logic [SG_W-1:0]    ang_sg;
  side_t              ang_side;

  su2aa_angle u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vin      (vc_r),
    .sumsq    (sumsq_r),
    .side_in  (cside_r),
    .vout     (ang_v),
    .theta    (ang_theta),
    .sg       (ang_sg),
    .side_out (ang_side)
  );

  // scale axis by theta / root, saturate
  logic [2:0][OUT_W-1:0] vec;

  su2aa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vin     (ang_v),
    .theta   (ang_theta),
    .sg      (ang_sg),
    .side_in (ang_side),
    .vout    (out_tvalid),
    .vec     (vec)
  );

  assign out_tdata = OUT_TDATA_W'({vec[2], vec[1], vec[0]});

  // a nonzero sum of squares is at least one, so the scaled root is at least 2^GUARD
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ang_v && !ang_side.zero |-> ang_sg >= SG_W'(1 << GUARD))
    else $error("scaled root below guard for nonzero axis");

  // an empty output register never blocks the input side
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with free output register");

  // an accepted word lands in the first stage
  a_first_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> va_r)
    else $error("accepted word lost at first stage");

  // stalled pipe keeps its first stage occupied
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && !en |=> va_r && $stable(ax_r) && $stable(kc_r))
    else $error("first stage changed during stall");

endmodule

// ===== tb/su2_axis_angle_vector_tb.sv =====
// Testbench for su2_axis_angle_vector: predicts each rotation vector and checks the stream.
`timescale 1ns / 1ps

module su2_axis_angle_vector_tb import su2aa_pkg::*; ();

  localparam int LAT       = 90;
  localparam int WDOG_LIM  = 20000;
  localparam int HOLD_LONG = 300;
  localparam longint ANG_HALF_PI = 64'd1686629713;
  localparam longint VEC_MAX = 262143;
  localparam longint VEC_MIN = -262144;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im (18b each)
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // vec_x, vec_y, vec_z (19b each), zero pad to 64b
  logic [OUT_TDATA_W-1:0] out_tdata;

  typedef logic signed [IN_W-1:0] part_t;
  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
  } rotvec_t;

  rotvec_t rotvec_q[$];
  bit      failed;
  bit      quiet;        // no idling on either side
  bit      hold_req;     // ask the receiver for one long hold-off
  int      wdog;

  su2_axis_angle_vector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor: integer root, 31-step CORDIC vectoring, rounded divide, clamp.
  // ---------------------------------------------------------------------------
  function automatic longint atan_q30(int i);
    longint t[31] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 8, 4, 2, 1};
    return t[i];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] scale_axis(longint comp, longint unsigned theta,
                                                  longint unsigned sg);
    longint unsigned mag, num, den, q;
    longint r;
    mag = (comp < 0) ? -comp : comp;
    num = theta * (mag << GUARD);
    den = sg << (ANG_BITS - 16);
    q = (num + (den >> 1)) / den;
    if (comp < 0) r = (q > -VEC_MIN) ? VEC_MIN : -longint'(q);
    else          r = (q > VEC_MAX) ? VEC_MAX : longint'(q);
    return r[OUT_W-1:0];
  endfunction

  function automatic rotvec_t predict_rotvec(logic [IN_TDATA_W-1:0] w);
    longint p[8];
    longint ax, by, cz, kc, kg, cx, cy, ang, xs, ys;
    longint unsigned sumsq, sg;
    rotvec_t v;
    for (int i = 0; i < 8; i++) p[i] = part_t'(w[i*IN_W +: IN_W]);
    ax = p[3] + p[5];
    by = p[2] - p[4];
    cz = p[7] - p[1];
    kc = p[0] + p[6];
    sumsq = ax*ax + by*by + cz*cz;
    if (sumsq == 0) begin
      v.x = '0; v.y = '0; v.z = '0;
      return v;
    end
    sg = int_sqrt(sumsq << (2*GUARD));
    kg = kc <<< GUARD;
    if (kg < 0) begin
      cx = sg; cy = -kg; ang = ANG_HALF_PI;
    end else begin
      cx = kg; cy = sg; ang = 0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx += ys; cy -= xs; ang += atan_q30(i);
      end else begin
        cx -= ys; cy += xs; ang -= atan_q30(i);
      end
    end
    if (ang < 0) ang = 0;
    v.x = scale_axis(ax, ang, sg);
    v.y = scale_axis(by, ang, sg);
    v.z = scale_axis(cz, ang, sg);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one word, with optional random idle burst ahead of it.
  // ---------------------------------------------------------------------------
  task automatic send_word(input longint m[8]);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) w[i*IN_W +: IN_W] = m[i][IN_W-1:0];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    rotvec_q.insert(rotvec_q.size(), predict_rotvec(w));
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rotvec_q.size() != 0) @(posedge clk);
  endtask

  function automatic longint rnd_part();
    return part_t'($urandom_range(0, 262143));
  endfunction

  // SU(2)-shaped: a random unnormalized quaternion-form matrix, with small noise on some words.
  task automatic send_unitary();
    longint m[8];
    longint a, b, c, d, noise;
    a = longint'($urandom_range(0, 131072)) - 65536;
    b = longint'($urandom_range(0, 131072)) - 65536;
    c = longint'($urandom_range(0, 131072)) - 65536;
    d = longint'($urandom_range(0, 131072)) - 65536;
    noise = $urandom_range(0, 3) == 0 ? 8 : 0;
    // U = [[a+ib, c+id], [-c+id, a-ib]]
    m = '{a, b, c, d, -c, d, a, -b};
    for (int i = 0; i < 8; i++)
      m[i] += longint'($urandom_range(0, 2*noise)) - noise;
    send_word(m);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    longint mx = 131071, mn = -131072, one = 65536;
    send_word('{one, 0, 0, 0, 0, 0, one, 0});        // identity: zero axis
    send_word('{mn, mx, 0, 0, 0, 0, mx, mx});        // zero axis from cancel
    send_word('{0, 0, 0, one, 0, one, 0, 0});        // X gate: theta=pi/2 on x
    send_word('{0, 0, one, 0, -one, 0, 0, 0});       // Y
    send_word('{0, -one, 0, 0, 0, 0, 0, one});       // Z
    send_word('{-one, 0, 0, 1, 0, 0, -one, 0});      // cos negative, tiny axis
    send_word('{-one, 0, 0, 0, 0, 0, -one, 1});      // -I nearly, z tiny
    send_word('{mx, mx, mx, mx, mx, mx, mx, mx});    // all max
    send_word('{mn, mn, mn, mn, mn, mn, mn, mn});    // all min
    send_word('{mn, mn, mx, mx, mn, mx, mn, mx});    // largest axis, cos min
    send_word('{mx, mx, mn, mn, mx, mn, mx, mn});
    send_word('{0, mx, mn, mn, mx, mn, 0, mn});      // large negative axis, K=0
    send_word('{0, mn, mx, mx, mn, mx, 0, mx});      // large positive axis, K=0
    send_word('{0, 0, 0, 1, 0, 0, 0, 0});            // smallest axis, K=0
    send_word('{mx, 0, 0, 0, 0, 1, mx, 0});          // smallest angle
    send_word('{mn, 0, 0, 0, 0, -1, mn, 0});         // near pi
    send_word('{-1, 0, 0, 0, 0, 0, 0, 1});           // K=-1 edge
    pause_sender();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_unitary();
      else begin
        longint m[8];
        foreach (m[k]) m[k] = rnd_part();
        send_word(m);
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, filling the pipe.
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(150);
    pause_sender();
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    test_random(60);
    pause_sender();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LONG) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Checker: compare each output word with the oldest prediction.
  always @(posedge clk) begin
    rotvec_t exp_v, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[0 +: OUT_W];
      got.y = out_tdata[OUT_W +: OUT_W];
      got.z = out_tdata[2*OUT_W +: OUT_W];
      if (rotvec_q.size() == 0) begin
        $display("%0t: output word with none expected: %h", $time, out_tdata);
        failed = 1'b1;
      end else begin
        exp_v = rotvec_q.pop_front();
        if (got.x !== exp_v.x) begin
          $display("%0t: vec_x exp %h got %h", $time, exp_v.x, got.x);
          failed = 1'b1;
        end
        if (got.y !== exp_v.y) begin
          $display("%0t: vec_y exp %h got %h", $time, exp_v.y, got.y);
          failed = 1'b1;
        end
        if (got.z !== exp_v.z) begin
          $display("%0t: vec_z exp %h got %h", $time, exp_v.z, got.z);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIM) begin
      $display("su2_axis_angle_vector_tb: FAIL");
      $finish;
    end
  end

  initial begin
    failed   = 1'b0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    wdog     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_backpressure();
    test_streaming();
    in_tvalid <= 1'b0;
    while (rotvec_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (!failed && rotvec_q.size() == 0) begin
      $display("su2_axis_angle_vector_tb: PASS");
    end else begin
      $display("su2_axis_angle_vector_tb: FAIL");
    end
    $finish;
  end

endmodule
